FILE: src/dssm_pkg.sv
// Shared types and constants for the dual stack block that keeps two stacks in one memory.
// It has no dependencies. The top level and the storage array import it.
package dssm_pkg;

  // Default memory depth and the fixed field widths.
  localparam int DSSM_DEPTH = 64;
  localparam int CAP_W      = 7;
  localparam int WORD_W     = 32;

  // Command codes on the cmd field. Code 3 is ignored.
  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_DUMP = 2'd2;

  // Status codes on the status field.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DUMP
  } state_t;

endpackage

FILE: src/dual_stack_shared_memory.sv
// Top level of the dual stack block. It holds the stack counters, the sequencer and the output
// register. It depends on dssm_pkg and dssm_ram.
//
// Usage: each input beat (cmd, side, value) is a push, a pop or a dump on the lower stack
// (side 0, grows up from entry 0) or the upper stack (side 1, grows down from entry
// capacity-1). Both stacks share one synchronous memory of DEPTH words. Results leave on the
// output channel as beats of (status, data, last).
// A push registers its result at the accept edge and leaves the block idle for the next beat.
// A pop issues the memory read at the accept edge and loads the registered read data from the
// read state. A dump first reads the stack's bottom word, then gives one beat per cycle for
// each stored word while the receiver does not stall. Its rate is set by the single read port.
// An empty pop or dump or a full push yields a status beat from idle; code 3 yields none.
// The output register releases a beat when the receiver does not stall. A new input beat is
// taken in the same cycle in which the pending result leaves. While out_stall is high the
// block holds its result, and it stalls the input or pauses a dump walk.
// A write to capacity (values 0 and above DEPTH are clamped) empties both stacks. Write it
// only while the block is idle. Reset empties both stacks, sets the capacity to DEPTH and
// needs no clearing pass, because no entry is read before it has been written.
module dual_stack_shared_memory import dssm_pkg::*; #(
  parameter int DEPTH = DSSM_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     capacity_write,
  input  logic [CAP_W-1:0]         capacity,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               cmd,
  input  logic                     side,
  input  logic signed [WORD_W-1:0] value,
  // output channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               status,
  output logic signed [WORD_W-1:0] data,
  output logic                     last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t state, state_next;

  logic [CW-1:0] cap_eff;
  logic [CW-1:0] lower_count, lower_count_next;
  logic [CW-1:0] upper_count, upper_count_next;
  logic [CW-1:0] dump_cursor, dump_cursor_next;
  logic          op_side, op_side_next;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  logic              out_free, accept;
  logic [CW-1:0]     sel_count, dump_count, cursor_inc;
  logic              mem_full, dump_last;
  logic              load;
  logic [1:0]        load_status;
  logic [WORD_W-1:0] load_data;

  dssm_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (value),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Handshake and shared conditions.
  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = !((state == ST_IDLE) && out_free);
  assign accept     = in_valid && !in_stall;
  assign sel_count  = side ? upper_count : lower_count;
  assign dump_count = op_side ? upper_count : lower_count;
  assign cursor_inc = CW'(dump_cursor + CW'(1));
  assign dump_last  = (cursor_inc == dump_count);
  assign mem_full   = ({1'b0, lower_count} + {1'b0, upper_count}) >= {1'b0, cap_eff};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && sel_count != '0) begin
          if (cmd == CMD_POP) begin
            state_next = ST_READ;
          end else if (cmd == CMD_DUMP) begin
            state_next = ST_DUMP;
          end
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      ST_DUMP: begin
        if (out_free && dump_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Memory accesses, counter updates and result loads for each state.
  always_comb begin
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    mem_waddr        = '0;
    mem_raddr        = '0;
    load             = 1'b0;
    load_status      = STATUS_OK;
    load_data        = '0;
    lower_count_next = lower_count;
    upper_count_next = upper_count;
    dump_cursor_next = dump_cursor;
    op_side_next     = op_side;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          op_side_next = side;
          case (cmd)
            CMD_PUSH: begin
              load = 1'b1;
              if (mem_full) begin
                load_status = STATUS_FULL;
              end else begin
                mem_we = 1'b1;
                if (side) begin
                  mem_waddr        = AW'(cap_eff - CW'(1) - upper_count);
                  upper_count_next = CW'(upper_count + CW'(1));
                end else begin
                  mem_waddr        = AW'(lower_count);
                  lower_count_next = CW'(lower_count + CW'(1));
                end
              end
            end
            CMD_POP: begin
              if (sel_count == '0) begin
                load        = 1'b1;
                load_status = STATUS_EMPTY;
              end else begin
                mem_re = 1'b1;
                if (side) begin
                  mem_raddr        = AW'(cap_eff - upper_count);
                  upper_count_next = CW'(upper_count - CW'(1));
                end else begin
                  mem_raddr        = AW'(lower_count - CW'(1));
                  lower_count_next = CW'(lower_count - CW'(1));
                end
              end
            end
            CMD_DUMP: begin
              if (sel_count == '0) begin
                load        = 1'b1;
                load_status = STATUS_EMPTY;
              end else begin
                mem_re           = 1'b1;
                mem_raddr        = side ? AW'(cap_eff - CW'(1)) : '0;
                dump_cursor_next = '0;
              end
            end
            default: begin
              load = 1'b0;
            end
          endcase
        end
      end
      ST_READ: begin
        load      = 1'b1;
        load_data = mem_rdata;
      end
      ST_DUMP: begin
        if (out_free) begin
          load      = 1'b1;
          load_data = mem_rdata;
          if (dump_last) begin
            dump_cursor_next = '0;
          end else begin
            dump_cursor_next = cursor_inc;
            mem_re           = 1'b1;
            mem_raddr        = op_side ? AW'(cap_eff - CW'(1) - cursor_inc) : AW'(cursor_inc);
          end
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cap_eff     <= CW'(DEPTH);
      lower_count <= '0;
      upper_count <= '0;
      dump_cursor <= '0;
      op_side     <= 1'b0;
    end else if (capacity_write) begin
      state       <= ST_IDLE;
      lower_count <= '0;
      upper_count <= '0;
      dump_cursor <= '0;
      if (capacity == '0) begin
        cap_eff <= CW'(1);
      end else if (capacity > CAP_W'(DEPTH)) begin
        cap_eff <= CW'(DEPTH);
      end else begin
        cap_eff <= CW'(capacity);
      end
    end else begin
      state       <= state_next;
      lower_count <= lower_count_next;
      upper_count <= upper_count_next;
      dump_cursor <= dump_cursor_next;
      op_side     <= op_side_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload. A pop or push result is always the final one of its item.
  always_ff @(posedge clk) begin
    if (load) begin
      status <= load_status;
      data   <= load_data;
      last   <= (state == ST_DUMP) ? dump_last : 1'b1;
    end
  end

  // The two stacks never hold more words than the effective capacity.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, lower_count} + {1'b0, upper_count}) <= {1'b0, cap_eff})
    else $error("stack counts exceed capacity");

  // The pop read returns into an empty output register.
  a_read_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> !out_valid)
    else $error("pop result would overwrite a pending beat");

  // A dump walk stays inside the stack being dumped.
  a_cursor_in_stack: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP) |-> (dump_cursor < dump_count))
    else $error("dump cursor beyond stack top");

  // The cursor rests at zero outside a dump.
  a_cursor_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_DUMP) |-> (dump_cursor == '0))
    else $error("dump cursor not cleared");

endmodule

FILE: src/dssm_ram.sv
// Word storage for the two stacks: one write port, one read port, and registered read data.
// It depends on dssm_pkg for the word width.
module dssm_ram import dssm_pkg::*; #(
  parameter int DEPTH = DSSM_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  // The write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // The read port. Data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: bench/dual_stack_shared_memory_test.sv
// Self-checking testbench for dual_stack_shared_memory: directed and random push, pop and dump
// beats against a scoreboard that tracks both stacks. Depends on dssm_pkg and the block's RTL.
module dual_stack_shared_memory_test import dssm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT   = 1_000_000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          HOLD_CYCLES   = 300;
  localparam logic [1:0]  CMD_IGNORED   = 2'd3;

  typedef struct packed {
    logic [1:0]        status;
    logic [WORD_W-1:0] data;
    logic              last;
  } beat_t;

  // Tracks both stack fills and the shared words, and queues the result beats each
  // accepted command should produce.
  class stack_scoreboard;
    logic [CAP_W-1:0]  capacity_reg;
    int unsigned       lo_fill;
    int unsigned       hi_fill;
    logic [WORD_W-1:0] words [DSSM_DEPTH];
    beat_t             pending [$];
    int unsigned       errors;

    function new();
      capacity_reg = CAP_W'(DSSM_DEPTH);
      lo_fill = 0;
      hi_fill = 0;
      errors = 0;
    endfunction

    // A capacity write moves the upper stack's base, so both stacks start over empty.
    function void write_capacity(logic [CAP_W-1:0] cap);
      capacity_reg = cap;
      lo_fill = 0;
      hi_fill = 0;
    endfunction

    function int unsigned span();
      if (capacity_reg == 0) return 1;
      if (capacity_reg > DSSM_DEPTH) return DSSM_DEPTH;
      return capacity_reg;
    endfunction

    function void expect_beat(logic [1:0] st, logic [WORD_W-1:0] word, logic fin);
      beat_t b;
      b.status = st;
      b.data = word;
      b.last = fin;
      pending.push_back(b);
    endfunction

    function void note_item(logic [1:0] op, logic upper, logic [WORD_W-1:0] word);
      int unsigned lim;
      int unsigned fill;
      int unsigned slot;
      lim = span();
      fill = upper ? hi_fill : lo_fill;
      case (op)
        CMD_PUSH: begin
          // The memory is full once both stacks together hold the whole capacity.
          if (lo_fill + hi_fill >= lim) begin
            expect_beat(STATUS_FULL, '0, 1'b1);
          end else begin
            if (upper) begin
              slot = lim - 1 - hi_fill;
              hi_fill++;
            end else begin
              slot = lo_fill;
              lo_fill++;
            end
            words[slot] = word;
            expect_beat(STATUS_OK, '0, 1'b1);
          end
        end
        CMD_POP: begin
          if (fill == 0) begin
            expect_beat(STATUS_EMPTY, '0, 1'b1);
          end else begin
            if (upper) begin
              hi_fill--;
              slot = lim - 1 - hi_fill;
            end else begin
              lo_fill--;
              slot = lo_fill;
            end
            expect_beat(STATUS_OK, words[slot], 1'b1);
          end
        end
        CMD_DUMP: begin
          // A dump walks from the stack's bottom to its top and marks the final beat.
          if (fill == 0) begin
            expect_beat(STATUS_EMPTY, '0, 1'b1);
          end else begin
            for (int i = 0; i < fill; i++) begin
              slot = upper ? lim - 1 - i : i;
              expect_beat(STATUS_OK, words[slot], i == fill - 1);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [1:0] st, logic [WORD_W-1:0] word, logic fin);
      beat_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result beat: status %0d data %h last %0b", st, word, fin);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (st !== exp.status) begin
        $error("status mismatch: expected %0d, got %0d", exp.status, st);
        errors++;
      end
      if (word !== exp.data) begin
        $error("data mismatch: expected %h, got %h", exp.data, word);
        errors++;
      end
      if (fin !== exp.last) begin
        $error("last mismatch: expected %0b, got %0b", exp.last, fin);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     capacity_write;
  logic [CAP_W-1:0]         capacity;
  logic                     in_valid;
  logic                     in_stall;
  logic [1:0]               cmd;
  logic                     side;
  logic signed [WORD_W-1:0] value;
  logic                     out_valid;
  logic                     out_stall;
  logic [1:0]               status;
  logic signed [WORD_W-1:0] data;
  logic                     last;

  stack_scoreboard sb;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              hold_request = 0;
  int unsigned     cycle_count = 0;

  dual_stack_shared_memory uut (
    .clk            (clk),
    .rst            (rst),
    .capacity_write (capacity_write),
    .capacity       (capacity),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .side           (side),
    .value          (value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .data           (data),
    .last           (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: random stall, or one long hold-off when requested so the block backs up.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Every result beat taken by the receiver goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(status, data, last);
    end
  end

  // Offers one input beat after a random idle gap and holds it until accepted.
  task automatic send_item(logic [1:0] op, logic upper, logic [WORD_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    cmd = op;
    side = upper;
    value = word;
    do @(posedge clk); while (in_stall);
    sb.note_item(op, upper, word);
    @(negedge clk);
  endtask

  // Waits until every expected beat has arrived and the block has had time to settle.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    wait_idle();
    capacity = cap;
    capacity_write = 1'b1;
    @(posedge clk);
    sb.write_capacity(cap);
    @(negedge clk);
    capacity_write = 1'b0;
  endtask

  // Random commands in chunks that lean toward filling, draining or mixing, so the
  // stacks regularly reach both full and empty.
  task automatic random_items(int count);
    int               done;
    int               chunk_left;
    int               mode;
    int               roll;
    logic [1:0]       op;
    logic [WORD_W-1:0] word;
    done = 0;
    chunk_left = 0;
    mode = 0;
    while (done < count) begin
      if (chunk_left == 0) begin
        mode = $urandom_range(2);
        chunk_left = $urandom_range(8, 24);
      end
      chunk_left--;
      roll = $urandom_range(99);
      case (mode)
        0: op = roll < 80 ? CMD_PUSH : roll < 90 ? CMD_POP : roll < 97 ? CMD_DUMP : CMD_IGNORED;
        1: op = roll < 15 ? CMD_PUSH : roll < 85 ? CMD_POP : roll < 97 ? CMD_DUMP : CMD_IGNORED;
        default: begin
          op = roll < 40 ? CMD_PUSH : roll < 75 ? CMD_POP : roll < 96 ? CMD_DUMP : CMD_IGNORED;
        end
      endcase
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0: word = 32'h8000_0000;
          1: word = 32'h7FFF_FFFF;
          2: word = 32'h0000_0000;
          default: word = 32'hFFFF_FFFF;
        endcase
      end else begin
        word = $urandom;
      end
      send_item(op, 1'($urandom_range(1)), word);
      if (op != CMD_IGNORED) done++;
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    capacity_write = 1'b0;
    capacity = '0;
    in_valid = 1'b0;
    cmd = CMD_PUSH;
    side = 1'b0;
    value = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 25;
    recv_idle_pct = 84;

    // Empty stacks, the ignored command, and extreme words on both sides at full depth.
    send_item(CMD_POP, 1'b0, '0);
    send_item(CMD_DUMP, 1'b1, '0);
    send_item(CMD_IGNORED, 1'b0, 32'hFFFF_FFFF);
    send_item(CMD_PUSH, 1'b0, 32'h8000_0000);
    send_item(CMD_PUSH, 1'b0, 32'h7FFF_FFFF);
    send_item(CMD_PUSH, 1'b1, 32'hFFFF_FFFF);
    send_item(CMD_PUSH, 1'b1, 32'h0000_0000);
    send_item(CMD_DUMP, 1'b0, '0);
    send_item(CMD_DUMP, 1'b1, '0);
    send_item(CMD_POP, 1'b1, '0);
    send_item(CMD_POP, 1'b0, '0);
    send_item(CMD_POP, 1'b0, '0);
    send_item(CMD_POP, 1'b0, '0);
    send_item(CMD_POP, 1'b1, '0);

    // A zero capacity acts as one entry: the second push is refused from either side.
    write_capacity(7'd0);
    send_item(CMD_PUSH, 1'b1, 32'h1234_5678);
    send_item(CMD_PUSH, 1'b0, 32'h0BAD_F00D);
    send_item(CMD_PUSH, 1'b1, 32'h0BAD_F00D);
    send_item(CMD_DUMP, 1'b1, '0);
    send_item(CMD_POP, 1'b1, '0);
    send_item(CMD_DUMP, 1'b0, '0);

    // A capacity above the depth acts as the full depth.
    write_capacity(7'd127);
    send_item(CMD_PUSH, 1'b0, 32'hA5A5_5A5A);
    send_item(CMD_DUMP, 1'b0, '0);
    send_item(CMD_POP, 1'b1, '0);

    write_capacity(7'd3);
    random_items(80);
    write_capacity(7'd64);
    random_items(80);

    send_idle_pct = 84;
    recv_idle_pct = 25;
    write_capacity(7'd1);
    random_items(80);
    write_capacity(7'd17);
    random_items(80);

    // No idling, with one long receiver hold-off so the input side backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_capacity(7'd7);
    hold_request = HOLD_CYCLES;
    random_items(80);
    write_capacity(7'd100);
    random_items(80);

    wait_idle();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
